### sv/gsth_pkg.sv
package gsth_pkg;

    // Block sizing
    localparam int HISTORY_DEPTH = 1024;
    localparam int GRID_COLS     = 480;
    localparam int GRID_ROWS     = 640;
    localparam int FRAME_WIDTH   = 640;
    localparam int FRAME_HEIGHT  = 480;
    localparam int SUBPIX        = 64;

    // Function codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Field widths
    localparam int POS_X_W = 16;
    localparam int POS_Y_W = 15;
    localparam int RIDX_W  = 10;
    localparam int CEN_X_W = 16;
    localparam int CEN_Y_W = 15;
    localparam int ENTRY_W = 11;

    localparam int CELL_X_W = $clog2(GRID_COLS);
    localparam int CELL_Y_W = $clog2(GRID_ROWS);

    // Ring sizing
    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int HELD_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (HELD_W > RIDX_W) ? HELD_W : RIDX_W;
    localparam int SUM_W  = ((PTR_W > RIDX_W) ? PTR_W : RIDX_W) + 1;
    localparam int ECMP_W = (HELD_W > ENTRY_W) ? HELD_W : ENTRY_W;

    // Snap: cell = floor(pos * K >> S), K = ceil((cells-1) * 2^S / size)
    localparam logic [63:0] SIZE_X = 64'(SUBPIX) * 64'(FRAME_WIDTH);
    localparam logic [63:0] SIZE_Y = 64'(SUBPIX) * 64'(FRAME_HEIGHT);

    localparam int SNAP_SX = POS_X_W + $clog2(SIZE_X) + 1;
    localparam int SNAP_SY = POS_Y_W + $clog2(SIZE_Y) + 1;
    localparam logic [63:0] SNAP_KX =
        ((64'(GRID_COLS - 1) << SNAP_SX) + SIZE_X - 64'd1) / SIZE_X;
    localparam logic [63:0] SNAP_KY =
        ((64'(GRID_ROWS - 1) << SNAP_SY) + SIZE_Y - 64'd1) / SIZE_Y;
    localparam int SNAP_KX_W = $clog2(SNAP_KX + 64'd1);
    localparam int SNAP_KY_W = $clog2(SNAP_KY + 64'd1);
    localparam int SNAP_RX_W = (POS_X_W + SNAP_KX_W - SNAP_SX > CELL_X_W) ?
                               (POS_X_W + SNAP_KX_W - SNAP_SX) : CELL_X_W;
    localparam int SNAP_RY_W = (POS_Y_W + SNAP_KY_W - SNAP_SY > CELL_Y_W) ?
                               (POS_Y_W + SNAP_KY_W - SNAP_SY) : CELL_Y_W;
    localparam int SNAP_PX_W = SNAP_SX + SNAP_RX_W;
    localparam int SNAP_PY_W = SNAP_SY + SNAP_RY_W;

    // Centre: v = floor(n / D), n = (2c+1)*size + cells-1, D = 2*(cells-1),
    // folded into one multiply-add: v = (c*A + B) >> S
    localparam logic [63:0] CX_D    = 64'(2 * (GRID_COLS - 1));
    localparam logic [63:0] CY_D    = 64'(2 * (GRID_ROWS - 1));
    localparam logic [63:0] CX_NMAX = 64'(2 * (GRID_COLS - 2) + 1) * SIZE_X
                                      + 64'(GRID_COLS - 1);
    localparam logic [63:0] CY_NMAX = 64'(2 * (GRID_ROWS - 2) + 1) * SIZE_Y
                                      + 64'(GRID_ROWS - 1);
    localparam int CX_S = $clog2(CX_NMAX * CX_D) + 1;
    localparam int CY_S = $clog2(CY_NMAX * CY_D) + 1;
    localparam logic [63:0] CX_M = ((64'd1 << CX_S) + CX_D - 64'd1) / CX_D;
    localparam logic [63:0] CY_M = ((64'd1 << CY_S) + CY_D - 64'd1) / CY_D;
    localparam logic [63:0] CX_A = 64'd2 * SIZE_X * CX_M;
    localparam logic [63:0] CY_A = 64'd2 * SIZE_Y * CY_M;
    localparam logic [63:0] CX_B = (SIZE_X + 64'(GRID_COLS - 1)) * CX_M;
    localparam logic [63:0] CY_B = (SIZE_Y + 64'(GRID_ROWS - 1)) * CY_M;
    localparam int CX_PW = $clog2(CX_A * 64'(GRID_COLS - 2) + CX_B + 64'd1);
    localparam int CY_PW = $clog2(CY_A * 64'(GRID_ROWS - 2) + CY_B + 64'd1);
    localparam int CX_QW = (CX_PW - CX_S > 1) ? (CX_PW - CX_S) : 1;
    localparam int CY_QW = (CY_PW - CY_S > 1) ? (CY_PW - CY_S) : 1;
    localparam int CX_PROD_W = CX_S + CX_QW;
    localparam int CY_PROD_W = CY_S + CY_QW;
    localparam int CX_CMP_W  = (CX_QW > CEN_X_W) ? CX_QW : CEN_X_W;
    localparam int CY_CMP_W  = (CY_QW > CEN_Y_W) ? CY_QW : CEN_Y_W;

    typedef struct packed {
        logic               func;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [RIDX_W-1:0]  read_index;
    } gsth_in_t;

    typedef struct packed {
        logic [CEN_X_W-1:0] center_x;
        logic [CEN_Y_W-1:0] center_y;
        logic               valid_res;
        logic               stored;
        logic [ENTRY_W-1:0] entry_count;
    } gsth_out_t;

    typedef struct packed {
        logic [CELL_X_W-1:0] cell_x;
        logic [CELL_Y_W-1:0] cell_y;
    } gsth_cell_t;

    typedef struct packed {
        logic              func;
        gsth_cell_t        grid_pos;
        logic [RIDX_W-1:0] read_index;
    } gsth_snap_t;

    typedef struct packed {
        logic               func;
        gsth_cell_t         grid_pos;
        logic               valid_res;
        logic               stored;
        logic [ENTRY_W-1:0] entry_count;
    } gsth_ring_t;

endpackage

### sv/gsth_snap.sv
module gsth_snap (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gsth_pkg::gsth_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gsth_pkg::gsth_snap_t out_data
);
    import gsth_pkg::*;

    logic                 valid_reg;
    gsth_snap_t           data_reg;
    gsth_snap_t           data_next;
    logic [SNAP_PX_W-1:0] prod_x;
    logic [SNAP_PY_W-1:0] prod_y;
    logic [SNAP_RX_W-1:0] raw_x;
    logic [SNAP_RY_W-1:0] raw_y;

    assign in_ready = !valid_reg || out_ready;

    // one constant multiply per axis, quotient is the top bits
    assign prod_x = SNAP_PX_W'(in_data.pos_x) * SNAP_PX_W'(SNAP_KX);
    assign prod_y = SNAP_PY_W'(in_data.pos_y) * SNAP_PY_W'(SNAP_KY);
    assign raw_x  = prod_x[SNAP_PX_W-1:SNAP_SX];
    assign raw_y  = prod_y[SNAP_PY_W-1:SNAP_SY];

    always_comb begin
        data_next.func       = in_data.func;
        data_next.read_index = in_data.read_index;
        // clamp at the far edge
        if (raw_x > SNAP_RX_W'(GRID_COLS - 2)) begin
            data_next.grid_pos.cell_x = CELL_X_W'(GRID_COLS - 2);
        end else begin
            data_next.grid_pos.cell_x = raw_x[CELL_X_W-1:0];
        end
        if (raw_y > SNAP_RY_W'(GRID_ROWS - 2)) begin
            data_next.grid_pos.cell_y = CELL_Y_W'(GRID_ROWS - 2);
        end else begin
            data_next.grid_pos.cell_y = raw_y[CELL_Y_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/gsth_ring.sv
module gsth_ring (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gsth_pkg::gsth_snap_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gsth_pkg::gsth_ring_t out_data,
    output gsth_pkg::gsth_cell_t out_rd_cell
);
    import gsth_pkg::*;

    gsth_cell_t        mem [HISTORY_DEPTH];

    logic              valid_reg;
    gsth_ring_t        data_reg;
    gsth_ring_t        data_next;
    gsth_cell_t        rd_cell_reg;

    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    gsth_cell_t        last_reg;

    logic              load;
    logic              is_add;
    logic              store;
    logic              rd_ok;
    logic [SUM_W-1:0]  idx_sum;
    logic [SUM_W-1:0]  idx_wrap;
    logic [PTR_W-1:0]  rd_idx;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign is_add   = (in_data.func == FUNC_ADD);

    // first add always stores; later ones only when the cell moves
    assign store = is_add && ((held_reg == '0) || (in_data.grid_pos != last_reg));

    always_comb begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        held_next    = held_reg;
        if (store) begin
            if (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
            if (held_reg < HELD_W'(HISTORY_DEPTH)) begin
                held_next = held_reg + 1'b1;
            end
        end
    end

    // age-ordered index: oldest entry sits at the write pointer once wrapped
    assign rd_ok    = CMP_W'(in_data.read_index) < CMP_W'(held_reg);
    assign idx_sum  = SUM_W'(wp_reg) + SUM_W'(in_data.read_index);
    assign idx_wrap = (idx_sum >= SUM_W'(HISTORY_DEPTH)) ?
                      (idx_sum - SUM_W'(HISTORY_DEPTH)) : idx_sum;
    assign rd_idx   = wrapped_reg ? idx_wrap[PTR_W-1:0] :
                      PTR_W'(in_data.read_index);

    always_comb begin
        data_next.func      = in_data.func;
        data_next.grid_pos  = in_data.grid_pos;
        data_next.valid_res = is_add ? 1'b1 : rd_ok;
        data_next.stored    = store;
        if (ECMP_W'(held_next) > ECMP_W'({ENTRY_W{1'b1}})) begin
            data_next.entry_count = {ENTRY_W{1'b1}};
        end else begin
            data_next.entry_count = held_next[ENTRY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            held_reg    <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                wp_reg      <= wp_next;
                wrapped_reg <= wrapped_next;
                held_reg    <= held_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            if (store) begin
                last_reg <= in_data.grid_pos;
            end
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (load && store) begin
            mem[wp_reg] <= in_data.grid_pos;
        end
        if (load) begin
            rd_cell_reg <= mem[rd_idx];
        end
    end

    assign out_valid   = valid_reg;
    assign out_data    = data_reg;
    assign out_rd_cell = rd_cell_reg;

endmodule

### sv/gsth_centre.sv
module gsth_centre (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gsth_pkg::gsth_ring_t in_data,
    input  gsth_pkg::gsth_cell_t in_rd_cell,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gsth_pkg::gsth_out_t  out_data
);
    import gsth_pkg::*;

    logic                 valid_reg;
    gsth_out_t            data_reg;
    gsth_out_t            data_next;
    gsth_cell_t           sel_pos;
    logic [CX_PROD_W-1:0] prod_x;
    logic [CY_PROD_W-1:0] prod_y;
    logic [CX_QW-1:0]     q_x;
    logic [CY_QW-1:0]     q_y;
    logic [CEN_X_W-1:0]   sat_x;
    logic [CEN_Y_W-1:0]   sat_y;

    assign in_ready = !valid_reg || out_ready;

    assign sel_pos = (in_data.func == FUNC_READ) ? in_rd_cell : in_data.grid_pos;

    // reciprocal multiply-add gives the rounded centre exactly
    assign prod_x = CX_PROD_W'(sel_pos.cell_x) * CX_PROD_W'(CX_A) + CX_PROD_W'(CX_B);
    assign prod_y = CY_PROD_W'(sel_pos.cell_y) * CY_PROD_W'(CY_A) + CY_PROD_W'(CY_B);
    assign q_x    = prod_x[CX_PROD_W-1:CX_S];
    assign q_y    = prod_y[CY_PROD_W-1:CY_S];

    assign sat_x = (CX_CMP_W'(q_x) > CX_CMP_W'({CEN_X_W{1'b1}})) ?
                   {CEN_X_W{1'b1}} : CEN_X_W'(q_x);
    assign sat_y = (CY_CMP_W'(q_y) > CY_CMP_W'({CEN_Y_W{1'b1}})) ?
                   {CEN_Y_W{1'b1}} : CEN_Y_W'(q_y);

    always_comb begin
        data_next.center_x    = in_data.valid_res ? sat_x : '0;
        data_next.center_y    = in_data.valid_res ? sat_y : '0;
        data_next.valid_res   = in_data.valid_res;
        data_next.stored      = in_data.stored;
        data_next.entry_count = in_data.entry_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/grid_snapped_track_history_top.sv
// Pipeline: the accepting edge loads the input register; snap, history
// memory access and centre each add one register stage after it.
// Throughput: one beat per cycle unless m_ready stalls the output; the
// history memory takes one write and one registered read per cycle.
// Reset: aresetn is synchronous, active low; it empties the pipe and
// clears the write pointer, wrap flag and entry count.
module grid_snapped_track_history_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gsth_pkg::gsth_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gsth_pkg::gsth_out_t m_data
);
    import gsth_pkg::*;

    // input register
    logic       in_valid_reg;
    gsth_in_t   in_data_reg;

    // snap stage -> ring stage
    logic       snap_valid;
    logic       snap_ready;
    gsth_snap_t snap_data;

    // ring stage -> centre stage
    logic       ring_valid;
    logic       ring_ready;
    gsth_ring_t ring_data;
    gsth_cell_t ring_rd_cell;
    logic       centre_ready;

    // every stage frees itself when its downstream takes the beat, so a
    // stalled result never blocks intake while a slot is still empty
    assign s_ready = !in_valid_reg || snap_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // position to grid cell, clamped at the frame edge
    gsth_snap u_snap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (snap_ready),
        .in_data   (in_data_reg),
        .out_valid (snap_valid),
        .out_ready (ring_ready),
        .out_data  (snap_data)
    );

    // duplicate filter, ring pointer, entry count and history memory
    gsth_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (snap_valid),
        .in_ready    (ring_ready),
        .in_data     (snap_data),
        .out_valid   (ring_valid),
        .out_ready   (centre_ready),
        .out_data    (ring_data),
        .out_rd_cell (ring_rd_cell)
    );

    // cell to rounded centre, and the output register
    gsth_centre u_centre (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (ring_valid),
        .in_ready   (centre_ready),
        .in_data    (ring_data),
        .in_rd_cell (ring_rd_cell),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (m_data)
    );

endmodule

### tb/sv/gsth_track_checker.sv
// Watches both channels of the track history block, keeps its own copy of the
// cell ring and compares every result beat with the expected one.
module gsth_track_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  gsth_pkg::gsth_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  gsth_pkg::gsth_out_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  n_stored,
    output int                  n_dup,
    output int                  n_read_hit,
    output int                  n_read_miss,
    output int                  n_wraps
);
    import gsth_pkg::*;

    localparam longint unsigned CX_LIMIT    = (64'd1 << CEN_X_W) - 1;
    localparam longint unsigned CY_LIMIT    = (64'd1 << CEN_Y_W) - 1;
    localparam int unsigned     COUNT_LIMIT = (1 << ENTRY_W) - 1;

    typedef struct packed {
        logic [CELL_X_W-1:0] cx;
        logic [CELL_Y_W-1:0] cy;
    } track_cell_t;

    track_cell_t cell_ring [HISTORY_DEPTH];
    int unsigned wr_ptr;
    bit          ring_wrapped;
    int unsigned held;
    track_cell_t last_pair;
    gsth_out_t   expected_q [$];
    int          errs;

    function automatic longint unsigned snap_to_cell(longint unsigned pos,
                                                     longint unsigned cells,
                                                     longint unsigned size);
        longint unsigned c;
        c = (pos * (cells - 1)) / (SUBPIX * size);
        if (c > cells - 2) c = cells - 2;
        return c;
    endfunction

    // Centre of a cell, rounded half up to 1/64 pixel, saturated to the field
    function automatic longint unsigned cell_centre(longint unsigned c,
                                                    longint unsigned cells,
                                                    longint unsigned size,
                                                    longint unsigned limit);
        longint unsigned v;
        v = ((2 * c + 1) * size * SUBPIX + cells - 1) / (2 * (cells - 1));
        return (v > limit) ? limit : v;
    endfunction

    function automatic gsth_out_t centre_of(track_cell_t p);
        gsth_out_t res;
        res           = '0;
        res.center_x  = CEN_X_W'(cell_centre(p.cx, GRID_COLS, FRAME_WIDTH, CX_LIMIT));
        res.center_y  = CEN_Y_W'(cell_centre(p.cy, GRID_ROWS, FRAME_HEIGHT, CY_LIMIT));
        res.valid_res = 1'b1;
        return res;
    endfunction

    // Advances the ring by one beat and gives the result that beat should make
    function automatic gsth_out_t track_step(gsth_in_t beat);
        gsth_out_t   res;
        track_cell_t p;
        bit          keep;
        int unsigned slot;
        res = '0;
        if (beat.func == FUNC_ADD) begin
            p.cx = CELL_X_W'(snap_to_cell(beat.pos_x, GRID_COLS, FRAME_WIDTH));
            p.cy = CELL_Y_W'(snap_to_cell(beat.pos_y, GRID_ROWS, FRAME_HEIGHT));
            keep = (held == 0) || (p != last_pair);
            if (keep) begin
                cell_ring[wr_ptr] = p;
                wr_ptr++;
                if (wr_ptr >= HISTORY_DEPTH) begin
                    wr_ptr       = 0;
                    ring_wrapped = 1'b1;
                    n_wraps++;
                end
                if (held < HISTORY_DEPTH) held++;
                last_pair = p;
                n_stored++;
            end else begin
                n_dup++;
            end
            res        = centre_of(p);
            res.stored = keep;
        end else if (beat.read_index < held) begin
            slot = ring_wrapped ? (wr_ptr + beat.read_index) % HISTORY_DEPTH
                                : beat.read_index;
            res  = centre_of(cell_ring[slot]);
            n_read_hit++;
        end else begin
            n_read_miss++;
        end
        res.entry_count = ENTRY_W'((held > COUNT_LIMIT) ? COUNT_LIMIT : held);
        return res;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            errs++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        gsth_out_t want;
        if (!aresetn) begin
            wr_ptr       = 0;
            ring_wrapped = 1'b0;
            held         = 0;
            last_pair    = '0;
            expected_q.delete();
        end else begin
            // results first, so a stray beat is never matched to this edge's input
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errs++;
                    $display("%0t: result beat, expected none, got %h", $time, m_data);
                end else begin
                    want = expected_q.pop_front();
                    check_field("center_x", want.center_x, m_data.center_x);
                    check_field("center_y", want.center_y, m_data.center_y);
                    check_field("valid_res", want.valid_res, m_data.valid_res);
                    check_field("stored", want.stored, m_data.stored);
                    check_field("entry_count", want.entry_count, m_data.entry_count);
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(track_step(s_data));
        end
        pending    <= expected_q.size();
        fail_count <= errs;
    end

endmodule

### tb/sv/tb_grid_snapped_track_history_top.sv
// Stimulus and verdict for the track history block. All prediction and
// comparison lives in the checker instance beside the block.
module tb_grid_snapped_track_history_top;
    import gsth_pkg::*;

    // Phase A is add-heavy so the ring fills and wraps; phase B mixes reads
    // in once the ring holds a full, wrapped history.
    localparam int PHASE_A_BEATS = 1200;
    localparam int PHASE_B_BEATS = 200;
    localparam int DRAIN_LIMIT   = 20000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_MOSTLY} rx_mode_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    gsth_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    gsth_out_t m_data;

    int fail_count;
    int pending;
    int n_stored;
    int n_dup;
    int n_read_hit;
    int n_read_miss;
    int n_wraps;

    // Sender burst state and the last position added, for duplicate and jitter
    // samples that land in the same cell.
    int          burst_left = 0;
    logic [15:0] last_px    = '0;
    logic [14:0] last_py    = '0;

    rx_mode_e rx_mode = RX_OPEN;
    int       rx_left = 0;

    always #5 aclk = ~aclk;

    grid_snapped_track_history_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    gsth_track_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_stored    (n_stored),
        .n_dup       (n_dup),
        .n_read_hit  (n_read_hit),
        .n_read_miss (n_read_miss),
        .n_wraps     (n_wraps)
    );

    // Receiver: picks a stall mode, holds it for a random stretch, then picks
    // again. RX_OPEN gives long runs with no back-pressure at all.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= $urandom_range(0, 1) == 1;
            RX_SLOW:   m_ready <= $urandom_range(0, 3) == 0;
            default:   m_ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    function automatic gsth_in_t make_beat(logic func, int unsigned px, int unsigned py,
                                           int unsigned ri);
        gsth_in_t beat;
        beat            = '0;
        beat.func       = func;
        beat.pos_x      = POS_X_W'(px);
        beat.pos_y      = POS_Y_W'(py);
        beat.read_index = RIDX_W'(ri);
        return beat;
    endfunction

    // Add sample: a repeat of the last position, a small jitter around it
    // (mostly the same cell), or a fresh position inside the frame, anywhere
    // in the field, or hugging the far edge where the clamp bites.
    function automatic gsth_in_t random_add(int repeat_pct, int jitter_pct);
        int roll;
        int px;
        int py;
        roll = $urandom_range(0, 99);
        if (roll < repeat_pct) begin
            px = last_px;
            py = last_py;
        end else if (roll < repeat_pct + jitter_pct) begin
            px = int'(last_px) + int'($urandom_range(0, 80)) - 40;
            py = int'(last_py) + int'($urandom_range(0, 80)) - 40;
            px = (px < 0) ? 0 : (px > 65535) ? 65535 : px;
            py = (py < 0) ? 0 : (py > 32767) ? 32767 : py;
        end else if (roll < 85) begin
            px = $urandom_range(0, FRAME_WIDTH * SUBPIX);
            py = $urandom_range(0, FRAME_HEIGHT * SUBPIX);
        end else if (roll < 95) begin
            px = $urandom_range(0, 65535);
            py = $urandom_range(0, 32767);
        end else begin
            px = $urandom_range(FRAME_WIDTH * SUBPIX - 260, FRAME_WIDTH * SUBPIX + 260);
            py = $urandom_range(FRAME_HEIGHT * SUBPIX - 260, FRAME_HEIGHT * SUBPIX + 260);
        end
        return make_beat(FUNC_ADD, px, py, $urandom_range(0, 1023));
    endfunction

    // Read: the whole index range, or clustered at the oldest and newest ends
    function automatic gsth_in_t random_read();
        int          roll;
        int unsigned ri;
        roll = $urandom_range(0, 3);
        if (roll < 2)
            ri = $urandom_range(0, 1023);
        else if (roll == 2)
            ri = $urandom_range(0, 31);
        else
            ri = $urandom_range(992, 1023);
        return make_beat(FUNC_READ, $urandom_range(0, 65535), $urandom_range(0, 32767), ri);
    endfunction

    // Offers one beat and waits for the edge it is taken. Valid stays high
    // across a burst; at a burst's end it drops for a random gap before return.
    task automatic send_beat(input gsth_in_t beat);
        int gap;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (beat.func == FUNC_ADD) begin
            last_px = beat.pos_x;
            last_py = beat.pos_y;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap     = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 7);
        end
    endtask

    // Hold the sender off until every outstanding result has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int n;
        int waited;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first add, duplicates, frame-edge clamp, beyond-frame
        // clamp, cell boundaries, reads of held and unheld entries.
        send_beat(make_beat(FUNC_ADD, 0, 0, 0));
        send_beat(make_beat(FUNC_ADD, 0, 0, 0));
        send_beat(make_beat(FUNC_ADD, 10, 10, 0));
        send_beat(make_beat(FUNC_READ, 0, 0, 0));
        send_beat(make_beat(FUNC_READ, 0, 0, 1));
        send_beat(make_beat(FUNC_READ, 0, 0, 1023));
        send_beat(make_beat(FUNC_ADD, 40960, 30720, 0));
        send_beat(make_beat(FUNC_ADD, 65535, 32767, 0));
        send_beat(make_beat(FUNC_ADD, 40959, 30719, 0));
        send_beat(make_beat(FUNC_ADD, 85, 47, 0));
        send_beat(make_beat(FUNC_ADD, 86, 49, 0));
        send_beat(make_beat(FUNC_ADD, 0, 32767, 0));
        send_beat(make_beat(FUNC_ADD, 65535, 0, 0));
        send_beat(make_beat(FUNC_ADD, 0, 0, 1023));
        send_beat(make_beat(FUNC_ADD, 'h5555, 'h2AAA, 'h155));
        send_beat(make_beat(FUNC_ADD, 'hAAAA, 'h5555, 'h2AA));
        send_beat(make_beat(FUNC_READ, 65535, 32767, 0));
        send_beat(make_beat(FUNC_READ, 0, 0, 5));
        send_beat(make_beat(FUNC_READ, 0, 0, 8));
        send_beat(make_beat(FUNC_READ, 0, 0, 9));
        send_beat(make_beat(FUNC_READ, 'h5555, 'h2AAA, 'h2AA));
        send_beat(make_beat(FUNC_READ, 'hAAAA, 'h5555, 'h155));
        wait_for_drain();

        // Phase A: mostly fresh adds, enough to fill and wrap the ring
        for (n = 0; n < PHASE_A_BEATS; n++) begin
            if (n == PHASE_A_BEATS / 2) wait_for_drain();
            if ($urandom_range(0, 99) < 4)
                send_beat(random_read());
            else
                send_beat(random_add(4, 4));
        end
        wait_for_drain();

        // Phase B: reads of the wrapped ring mixed with duplicate-rich adds
        for (n = 0; n < PHASE_B_BEATS; n++) begin
            if ($urandom_range(0, 1) == 0)
                send_beat(random_read());
            else
                send_beat(random_add(15, 15));
        end
        s_valid <= 1'b0;

        // Let the pipe empty, then a few more cycles to catch stray beats
        waited = 0;
        @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);

        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        $display("Covered %0d adds (%0d stored, %0d duplicates) and %0d reads (%0d held, %0d unheld).",
                 n_stored + n_dup, n_stored, n_dup, n_read_hit + n_read_miss,
                 n_read_hit, n_read_miss);
        $display("History ring wrapped %0d time(s) under random sender gaps and receiver stalls.",
                 n_wraps);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("%0t: run timed out", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
